// ===== design/isd_pkg.sv =====
// Shared constants and types for the IMU stillness detector.
`default_nettype none
package isd_pkg;

  localparam int WINDOW      = 100;
  localparam int SAMPLE_BITS = 16;
  localparam int NCH         = 6;
  localparam int NRATE       = 3;

  localparam int CNT_BITS    = $clog2(WINDOW + 2);
  localparam int SLOT_BITS   = $clog2(WINDOW);
  localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS;
  localparam int ITER_BITS   = $clog2(SUM_BITS);
  localparam int RING_BITS   = NCH * SAMPLE_BITS;
  localparam int DATA_BITS   = ((RING_BITS + 7) / 8) * 8;

  localparam int THR_BITS    = 16;
  localparam int DEV_BITS    = SAMPLE_BITS + 1;
  localparam int CMP_BITS    = (DEV_BITS > THR_BITS + 1) ? DEV_BITS : THR_BITS + 1;
  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(30);

  localparam int CFG_IDX_BITS = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_GYRO_TH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ACCEL_TH = CFG_IDX_BITS'(1);

  localparam int USER_BITS  = 2;
  localparam int USR_MOVING = 0;
  localparam int USR_READY  = 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  typedef struct packed {
    logic load;    // take the sample, add it to the sums
    logic prep;    // set up the dividers
    logic step;    // one quotient bit
    logic finish;  // judge, retire oldest sample, load result
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== design/isd_ctrl.sv =====
// Sequencer for the stillness detector: accept, divide, finish, hand off.
`default_nettype none
module isd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              m_tready,
  output logic                   m_tvalid,
  output isd_pkg::ctrl_cmd_t     cmd
);
  import isd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREP   = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [ITER_BITS-1:0] iter;
  logic                 out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (iter == '0) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      iter     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.prep) iter <= ITER_BITS'(SUM_BITS - 1);
      else if (cmd.step) iter <= iter - 1'b1;
      if (cmd.finish) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/isd_datapath.sv =====
// Sample ring, running sums, six bit-serial dividers and the deviation test.
`default_nettype none
module isd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire isd_pkg::ctrl_cmd_t            cmd,
  input  wire logic [isd_pkg::DATA_BITS-1:0] in_data,
  input  wire logic [isd_pkg::THR_BITS-1:0]  gyro_th,
  input  wire logic [isd_pkg::THR_BITS-1:0]  accel_th,
  output logic [isd_pkg::DATA_BITS-1:0]      res_data,
  output logic [isd_pkg::USER_BITS-1:0]      res_user
);
  import isd_pkg::*;

  sample_t              smp [NCH];
  sum_t                 sums [NCH];
  logic [SUM_BITS-1:0]  quo [NCH];
  logic [CNT_BITS-1:0]  rem [NCH];
  logic                 neg [NCH];
  logic [CNT_BITS-1:0]  divisor;
  logic [CNT_BITS-1:0]  fill_count;
  logic [SLOT_BITS-1:0] oldest;
  logic                 moving_flag;

  logic [RING_BITS-1:0] ring [WINDOW];
  logic [RING_BITS-1:0] ring_rd;
  logic [RING_BITS-1:0] smp_packed;
  logic [RING_BITS-1:0] mean_packed;
  logic [SLOT_BITS-1:0] wr_slot;

  logic                 full;
  logic                 mv;
  logic                 moving_res;
  logic                 full_after;
  logic                 step_bit [NCH];
  logic [CNT_BITS-1:0]  rem_next [NCH];

  assign full    = (fill_count == CNT_BITS'(WINDOW));
  assign wr_slot = full ? oldest : fill_count[SLOT_BITS-1:0];

  // one restoring-division step per channel
  always_comb begin
    logic [CNT_BITS:0] trial;
    for (int c = 0; c < NCH; c++) begin
      trial = {rem[c], quo[c][SUM_BITS-1]};
      step_bit[c] = (trial >= {1'b0, divisor});
      if (step_bit[c]) rem_next[c] = CNT_BITS'(trial - {1'b0, divisor});
      else rem_next[c] = trial[CNT_BITS-1:0];
    end
  end

  // means, deviations and the moving decision
  always_comb begin
    logic [SUM_BITS-1:0]  signed_q;
    sample_t              mean_c;
    logic signed [DEV_BITS-1:0] diff;
    logic [CMP_BITS-1:0]  dev;
    logic [CMP_BITS-1:0]  th;
    mv          = 1'b0;
    mean_packed = '0;
    smp_packed  = '0;
    for (int c = 0; c < NCH; c++) begin
      signed_q = neg[c] ? (~quo[c] + 1'b1) : quo[c];
      mean_c   = signed_q[SAMPLE_BITS-1:0];
      mean_packed[c*SAMPLE_BITS +: SAMPLE_BITS] = mean_c;
      smp_packed[c*SAMPLE_BITS +: SAMPLE_BITS]  = smp[c];
      diff = DEV_BITS'(smp[c]) - DEV_BITS'(mean_c);
      dev  = CMP_BITS'(diff[DEV_BITS-1] ? -diff : diff);
      th   = (c < NRATE) ? CMP_BITS'(gyro_th) : CMP_BITS'(accel_th);
      if (dev > th) mv = 1'b1;
    end
  end

  assign moving_res = full ? mv : moving_flag;
  assign full_after = full || (fill_count == CNT_BITS'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCH; c++) sums[c] <= '0;
      fill_count  <= '0;
      oldest      <= '0;
      moving_flag <= 1'b0;
    end else begin
      if (cmd.load) begin
        for (int c = 0; c < NCH; c++)
          sums[c] <= sums[c] + SUM_BITS'($signed(in_data[c*SAMPLE_BITS +: SAMPLE_BITS]));
      end else if (cmd.finish && full) begin
        for (int c = 0; c < NCH; c++)
          sums[c] <= sums[c] - SUM_BITS'($signed(ring_rd[c*SAMPLE_BITS +: SAMPLE_BITS]));
      end
      if (cmd.finish) begin
        if (full) begin
          moving_flag <= mv;
          oldest <= (oldest == SLOT_BITS'(WINDOW - 1)) ? '0 : oldest + 1'b1;
        end else begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NCH; c++) smp[c] <= in_data[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
    if (cmd.prep) begin
      divisor <= fill_count + 1'b1;
      for (int c = 0; c < NCH; c++) begin
        neg[c] <= sums[c][SUM_BITS-1];
        quo[c] <= sums[c][SUM_BITS-1] ? -sums[c] : sums[c];
        rem[c] <= '0;
      end
    end else if (cmd.step) begin
      for (int c = 0; c < NCH; c++) begin
        rem[c] <= rem_next[c];
        quo[c] <= {quo[c][SUM_BITS-2:0], step_bit[c]};
      end
    end
    if (cmd.finish) begin
      res_data <= DATA_BITS'(mean_packed);
      res_user[USR_MOVING] <= moving_res;
      res_user[USR_READY]  <= full_after && !moving_res;
    end
  end

  // sample ring: oldest slot read every cycle, written on finish
  always_ff @(posedge clk) begin
    if (cmd.finish) ring[wr_slot] <= smp_packed;
    ring_rd <= ring[oldest];
  end

endmodule
`default_nettype wire

// ===== design/imu_stillness_detector.sv =====
// Top level of the IMU stillness detector.
// Each input transaction carries one six-channel IMU sample (three rates, three
// accelerations, 16-bit two's complement). The block adds it to running sums,
// forms the six means over the stored samples plus the new one (truncated
// toward zero) and, once the window of WINDOW samples is full, flags the
// sample as moving if any rate deviates from its mean by more than
// gyro_threshold or any acceleration by more than accel_threshold. A
// deviation equal to a threshold counts as still. Before the window fills the
// moving flag keeps its value. One result transaction comes out per input.
// The six restoring dividers produce one quotient bit per cycle. The next
// sample is taken as soon as the result is in the output register, even if
// that result is still waiting. The sample ring needs no initialization;
// there is no clearing pass after reset. Thresholds are written through the
// cfg channel (index 0 gyro, 1 accel, other indexes ignored); the user must
// write them only while the block is idle, which the block itself does not
// enforce. Both reset to 30.
`default_nettype none
module imu_stillness_detector (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input sample
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
  input  wire logic [isd_pkg::DATA_BITS-1:0]        s_tdata,
  // result
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // mean_rate_x, mean_rate_y, mean_rate_z, mean_accel_x, mean_accel_y, mean_accel_z
  output logic [isd_pkg::DATA_BITS-1:0]             m_tdata,
  // moving, ready_res
  output logic [isd_pkg::USER_BITS-1:0]             m_tuser,
  // configuration writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [isd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [isd_pkg::THR_BITS-1:0]         cfg_data
);
  import isd_pkg::*;

  ctrl_cmd_t           cmd;
  logic [THR_BITS-1:0] gyro_th;
  logic [THR_BITS-1:0] accel_th;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_th  <= THR_RESET;
      accel_th <= THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GYRO_TH:  gyro_th  <= cfg_data;
        REG_ACCEL_TH: accel_th <= cfg_data;
        default: ;
      endcase
    end
  end

  isd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  isd_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .gyro_th  (gyro_th),
    .accel_th (accel_th),
    .res_data (m_tdata),
    .res_user (m_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/imu_stillness_detector_tb.sv =====
// Self-checking testbench for the IMU stillness detector: stream driver, monitor and predictor.
`timescale 1ns / 100ps
module imu_stillness_detector_tb;
  import isd_pkg::*;

  // Run shape: phase 0 runs on the reset thresholds, every later phase starts
  // with threshold writes made while the block is idle.
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 150;
  // Watchdog limit: longer than the slowest item's input gap, compute and output stall together.
  localparam int STALL_LIMIT     = 2000;
  // Quiet time after the last result, a bit over one item's latency.
  localparam int TAIL_CYCLES     = 40;

  // Six channels, rate_x in the lowest slot, same order as tdata.
  typedef sample_t [NCH-1:0] imu_vec_t;

  // One expected or observed result transaction.
  typedef struct packed {
    logic     moving;
    logic     ready;
    imu_vec_t mean;
  } verdict_t;

  // One queued input sample. When aim is nonzero and the window is full, the
  // driver replaces the sample just before sending it: aimed channels land
  // exactly on the threshold (or one past it when over is set), the others on
  // the window mean.
  typedef struct packed {
    imu_vec_t        smp;
    logic [NCH-1:0]  aim;
    logic [NCH-1:0]  aim_neg;
    logic            over;
  } sample_req_t;

  logic clk;
  logic rst = 1'b1;

  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [DATA_BITS-1:0]    s_tdata  = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [DATA_BITS-1:0]    m_tdata;
  logic [USER_BITS-1:0]    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [THR_BITS-1:0]     cfg_data  = '0;

  imu_stillness_detector u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own window ring, running sums and thresholds.
  // ---------------------------------------------------------------------------
  imu_vec_t            ring [WINDOW];
  int                  chan_sum [NCH] = '{default: 0};
  int                  fill      = 0;
  int                  oldest    = 0;
  logic                moving_q  = 1'b0;
  logic [THR_BITS-1:0] gyro_thr  = THR_RESET;
  logic [THR_BITS-1:0] accel_thr = THR_RESET;

  sample_req_t sample_q [$];   // samples waiting to be sent
  verdict_t    verdict_q [$];  // expected results, oldest first

  imu_vec_t cur_smp;           // sample currently on s_tdata
  int       in_wait   = 0;
  int       in_burst  = 0;
  int       out_wait  = 0;
  int       out_burst = 0;
  int       bad_count = 0;
  int       idle_cycles = 0;

  function automatic sample_t clamp16(int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  // Random per-item wait, with occasional bursts of no waiting.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  // Adds the sample, forms the means over stored + new samples (truncated
  // toward zero), judges it once the window is full, then retires the oldest.
  function automatic verdict_t window_step(imu_vec_t smp);
    verdict_t r;
    logic     mv;
    int       m;
    int       dev;
    int       thr;
    int       c;
    mv = 1'b0;
    for (c = 0; c < NCH; c++) chan_sum[c] += $signed(smp[c]);
    for (c = 0; c < NCH; c++) begin
      m = chan_sum[c] / (fill + 1);
      r.mean[c] = sample_t'(m);
      thr = (c < NRATE) ? int'(gyro_thr) : int'(accel_thr);
      dev = $signed(smp[c]) - m;
      if (dev < 0) dev = -dev;
      // equal to the threshold still counts as still
      if (dev > thr) mv = 1'b1;
    end
    if (fill >= WINDOW) begin
      moving_q = mv;
      for (c = 0; c < NCH; c++) chan_sum[c] -= $signed(ring[oldest][c]);
      ring[oldest] = smp;
      oldest = (oldest + 1) % WINDOW;
    end else begin
      // filling: no judgment, flag keeps its value
      ring[(oldest + fill) % WINDOW] = smp;
      fill++;
    end
    r.moving = moving_q;
    r.ready  = (fill == WINDOW) && !moving_q;
    return r;
  endfunction

  function automatic sample_req_t make_req(imu_vec_t v);
    sample_req_t r;
    r = '0;
    r.smp = v;
    return r;
  endfunction

  // Appends one sample to the send queue.
  function automatic void enqueue(sample_req_t r);
    sample_q.insert(sample_q.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one transaction per queued sample, random gap before each.
  // The prediction runs at the edge where the transaction is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sample_req_t nxt;
    int c, k, tgt, guess, x;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        verdict_q.insert(verdict_q.size(), window_step(cur_smp));
        in_wait = draw_gap(in_burst);
      end
      if (!s_tvalid || s_tready) begin
        if (in_wait > 0) begin
          in_wait--;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          // Aim at the threshold edge using the window as it stands now; all
          // earlier samples are already accepted and folded into the sums.
          if (nxt.aim != '0 && fill == WINDOW) begin
            for (c = 0; c < NCH; c++) begin
              tgt = 0;
              if (nxt.aim[c]) begin
                tgt = ((c < NRATE) ? int'(gyro_thr) : int'(accel_thr)) + int'(nxt.over);
                if (nxt.aim_neg[c]) tgt = -tgt;
              end
              // solve x - (sum + x) / (WINDOW + 1) == tgt; the left side
              // climbs by 0 or 1 per step of x, so a few neighbors suffice
              guess = (tgt * (WINDOW + 1) + chan_sum[c]) / WINDOW;
              nxt.smp[c] = clamp16(guess);
              for (k = -3; k <= 3; k++) begin
                x = guess + k;
                if (x >= -32768 && x <= 32767 &&
                    x - (chan_sum[c] + x) / (WINDOW + 1) == tgt)
                  nxt.smp[c] = sample_t'(x);
              end
            end
          end
          cur_smp  = nxt.smp;
          s_tdata  <= nxt.smp;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: field-by-field compare against the oldest expectation,
  // random stall after each result transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    verdict_t got, want;
    logic     bad;
    int       c;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.moving = m_tuser[USR_MOVING];
        got.ready  = m_tuser[USR_READY];
        got.mean   = m_tdata[RING_BITS-1:0];
        if (verdict_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("[%0t] result with no expectation: moving=%0b ready=%0b", $time,
                     got.moving, got.ready);
        end else begin
          want = verdict_q.pop_front();
          bad = (got.moving !== want.moving) || (got.ready !== want.ready);
          for (c = 0; c < NCH; c++)
            if (got.mean[c] !== want.mean[c]) bad = 1'b1;
          if (bad) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("[%0t] mismatch exp: moving=%0b ready=%0b means %0d %0d %0d %0d %0d %0d",
                       $time, want.moving, want.ready,
                       $signed(want.mean[0]), $signed(want.mean[1]), $signed(want.mean[2]),
                       $signed(want.mean[3]), $signed(want.mean[4]), $signed(want.mean[5]));
              $display("           got: moving=%0b ready=%0b means %0d %0d %0d %0d %0d %0d",
                       got.moving, got.ready,
                       $signed(got.mean[0]), $signed(got.mean[1]), $signed(got.mean[2]),
                       $signed(got.mean[3]), $signed(got.mean[4]), $signed(got.mean[5]));
            end
          end
        end
        out_wait = draw_gap(out_burst);
      end
      if (out_wait > 0) begin
        out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Threshold write; the predictor follows only the two known indexes.
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [THR_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GYRO_TH) gyro_thr = val;
    else if (idx == REG_ACCEL_TH) accel_thr = val;
  endtask

  // Block is idle once nothing is queued, in flight or expected.
  task automatic wait_idle();
    do @(negedge clk); while (sample_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: reset, a short directed set, then phases of random samples.
  // Even phases are mostly clean still data around a base, so the window
  // settles and ready comes up; odd phases mix in raw noise and spikes.
  // ---------------------------------------------------------------------------
  initial begin
    int          p, i, c, pick, amp, noise_pct, spike_pct;
    int          base [NCH];
    logic [THR_BITS-1:0] g_val, a_val;
    sample_req_t req;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: begin g_val = '0;          a_val = '0;          end
          2: begin g_val = '1;          a_val = '1;          end
          3: begin g_val = '1;          a_val = '0;          end
          4: begin g_val = '0;          a_val = '1;          end
          5: begin g_val = THR_BITS'($urandom_range(1, 300));
                   a_val = THR_BITS'($urandom_range(1, 300)); end
          6: begin g_val = THR_BITS'($urandom); a_val = THR_BITS'($urandom); end
          default: begin g_val = THR_RESET; a_val = THR_RESET; end
        endcase
        // unknown index must be ignored; all ones on the first try
        cfg_write((p == 1) ? '1 : CFG_IDX_BITS'($urandom_range(2, (1 << CFG_IDX_BITS) - 1)),
                  THR_BITS'($urandom));
        cfg_write(REG_GYRO_TH, g_val);
        cfg_write(REG_ACCEL_TH, a_val);
      end
      @(negedge clk);

      if (p == 0) begin
        // field extremes and sign patterns; these land in the filling phase
        // and check the truncation of negative means
        enqueue(make_req({NCH{16'h0000}}));
        enqueue(make_req({NCH{16'h7FFF}}));
        enqueue(make_req({NCH{16'h8000}}));
        enqueue(make_req({NCH{16'hFFFF}}));
        enqueue(make_req({NCH{16'h0001}}));
        enqueue(make_req({NCH{16'h5555}}));
        enqueue(make_req({NCH{16'hAAAA}}));
        enqueue(make_req({NCH{16'h8001}}));
        enqueue(make_req({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}));
        enqueue(make_req({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}));
        enqueue(make_req({16'hFFFD, 16'h0003, 16'hFFFE, 16'h0002, 16'hFFFF, 16'h0001}));
        enqueue(make_req({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}));
      end

      for (c = 0; c < NCH; c++)
        base[c] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32767 : -32768)
                                              : int'($urandom_range(0, 65535)) - 32768;
      amp       = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
      noise_pct = (p % 2) ? 20 : 2;
      spike_pct = (p % 2) ? 10 : 3;

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        req = '0;
        for (c = 0; c < NCH; c++)
          req.smp[c] = clamp16(base[c] + int'($urandom_range(0, 2 * amp)) - amp);
        pick = $urandom_range(0, 99);
        if (pick < noise_pct) begin
          req.smp = {$urandom, $urandom, $urandom};
        end else if (pick < noise_pct + spike_pct) begin
          c = $urandom_range(0, NCH - 1);
          req.smp[c] = clamp16(base[c] + ($urandom_range(0, 1) ? 1 : -1) *
                               int'($urandom_range(100, 40000)));
        end else if (pick < noise_pct + spike_pct + 25) begin
          // threshold edge: exactly on it stays still, one past it moves
          req.aim     = ($urandom_range(0, 3) == 0) ? NCH'($urandom)
                                                    : NCH'(1) << $urandom_range(0, NCH - 1);
          req.aim_neg = NCH'($urandom);
          req.over    = 1'($urandom_range(0, 1));
        end
        enqueue(req);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/isd_pkg.sv
design/isd_ctrl.sv
design/isd_datapath.sv
design/imu_stillness_detector.sv
tb/imu_stillness_detector_tb.sv
